@@ rtl/core/nrvs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package nrvs_pkg;

   localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
   localparam logic [31:0] CRC_ONES   = 32'hFFFF_FFFF;
   localparam logic [31:0] HALF_RANGE = 32'h8000_0000;
   localparam int          HDR_BITS   = 160;

   localparam logic [1:0] CSR_RECORD_MAGIC       = 2'd0;
   localparam logic [1:0] CSR_EXPECTED_SCHEMA    = 2'd1;
   localparam logic [1:0] CSR_MAX_PAYLOAD_LENGTH = 2'd2;

   typedef enum logic [1:0] {
      CMD_HEADER  = 2'd0,
      CMD_PAYLOAD = 2'd1,
      CMD_SELECT  = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      STATUS_OK          = 3'd0,
      STATUS_MAGIC       = 3'd1,
      STATUS_SCHEMA      = 3'd2,
      STATUS_LENGTH      = 3'd3,
      STATUS_HEADER_CRC  = 3'd4,
      STATUS_PAYLOAD_CRC = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      CHOSEN_NONE = 2'd0,
      CHOSEN_A    = 2'd1,
      CHOSEN_B    = 2'd2
   } chosen_type;

   typedef enum logic {
      KIND_STATUS = 1'b0,
      KIND_SELECT = 1'b1
   } kind_type;

   typedef struct packed {
      cmd_type     cmd;
      logic        slot;
      logic [31:0] hdr_magic;
      logic [15:0] hdr_schema;
      logic [15:0] hdr_spare;
      logic [31:0] hdr_sequence;
      logic [31:0] hdr_length;
      logic [31:0] hdr_payload_check;
      logic [31:0] hdr_header_check;
      logic [7:0]  data_byte;
      logic        last;
   } req_type;

   typedef struct packed {
      kind_type    result_kind;
      status_type  status;
      logic        status_slot;
      chosen_type  chosen;
      logic [31:0] chosen_sequence;
   } rsp_type;

   typedef struct packed {
      logic [31:0] record_magic;
      logic [15:0] expected_schema;
      logic [31:0] max_payload_length;
   } csr_type;

   typedef logic [HDR_BITS-1:0][31:0] crc_cols_type;

   function automatic logic [31:0] crc_bit_step(logic [31:0] crc, logic din);
      logic fb;
      fb = crc[0] ^ din;
      return (crc >> 1) ^ (fb ? CRC_POLY : 32'h0);
   endfunction

   function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] din);
      logic [31:0] c;
      c = crc ^ {24'h0, din};
      for (int i = 0; i < 8; i++) begin
         c = crc_bit_step(c, 1'b0);
      end
      return c;
   endfunction

   // contribution of each header bit to the final CRC (linear part)
   function automatic crc_cols_type hdr_crc_cols();
      crc_cols_type cols;
      logic [31:0]  c;
      for (int j = 0; j < HDR_BITS; j++) begin
         c = 32'h0;
         for (int n = 0; n < HDR_BITS; n++) begin
            c = crc_bit_step(c, n == j);
         end
         cols[j] = c;
      end
      return cols;
   endfunction

   // CRC of an all-zero header, including init and final inversion
   function automatic logic [31:0] hdr_crc_base();
      logic [31:0] c;
      c = CRC_ONES;
      for (int n = 0; n < HDR_BITS; n++) begin
         c = crc_bit_step(c, 1'b0);
      end
      return c ^ CRC_ONES;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/nrvs_hdr_check.sv @@
`timescale 1ns / 1ps
`default_nettype none

module nrvs_hdr_check
   import nrvs_pkg::*;
(
   input  wire req_type req,
   input  wire csr_type csr,
   output status_type   hdr_status
);

   localparam crc_cols_type HDR_COLS = hdr_crc_cols();
   localparam logic [31:0]  HDR_BASE = hdr_crc_base();

   logic [HDR_BITS-1:0] msg;
   logic [31:0]         hdr_crc;

   assign msg = {req.hdr_payload_check, req.hdr_length, req.hdr_sequence,
                 req.hdr_spare, req.hdr_schema, req.hdr_magic};

   always_comb begin
      hdr_crc = HDR_BASE;
      for (int i = 0; i < HDR_BITS; i++) begin
         if (msg[i]) begin
            hdr_crc = hdr_crc ^ HDR_COLS[i];
         end
      end
   end

   always_comb begin
      priority if (req.hdr_magic != csr.record_magic) begin
         hdr_status = STATUS_MAGIC;
      end else if (req.hdr_schema != csr.expected_schema) begin
         hdr_status = STATUS_SCHEMA;
      end else if (req.hdr_length > csr.max_payload_length) begin
         hdr_status = STATUS_LENGTH;
      end else if (hdr_crc != req.hdr_header_check) begin
         hdr_status = STATUS_HEADER_CRC;
      end else begin
         hdr_status = STATUS_OK;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/nvm_record_validate_select_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Validates A/B slot records and answers slot selection requests. A record is
// one header request followed by payload byte requests, the last flag ending
// it; the end of a record returns one status result, a select request returns
// the chosen slot and its sequence. One request is taken per cycle unless a
// stalled result holds it; each passes through the input register, then the
// header CRC / byte CRC logic into the result register, which a stall holds.

module nvm_record_validate_select_core
   import nrvs_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_payload,
   input  wire logic    csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   csr_type     csr_ff;
   logic        in_valid_ff, in_valid_in;
   req_type     in_ff;
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_ff, out_in;

   logic [31:0] crc_ff, crc_in;
   logic [31:0] seen_ff, seen_in;
   status_type  early_ff, early_in;
   logic [31:0] len_ff, len_in;
   logic [31:0] pchk_ff, pchk_in;
   logic        cur_slot_ff, cur_slot_in;
   logic [1:0]  slot_valid_ff, slot_valid_in;
   logic [1:0][31:0] slot_seq_ff, slot_seq_in;
   logic        open_ff, open_in;

   status_type  hdr_status;
   status_type  fin_status;
   logic        advance;
   logic        finish;
   logic        has_result;
   logic [31:0] seq_diff;
   logic        b_newer;

   nrvs_hdr_check u_hdr_check (
      .req        (in_ff),
      .csr        (csr_ff),
      .hdr_status (hdr_status)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_payload = out_ff;

   assign seq_diff = slot_seq_ff[1] - slot_seq_ff[0];
   assign b_newer  = (slot_seq_ff[1] != slot_seq_ff[0]) && (seq_diff < HALF_RANGE);

   always_comb begin
      priority if (early_in == STATUS_MAGIC || early_in == STATUS_SCHEMA ||
                   early_in == STATUS_LENGTH) begin
         fin_status = early_in;
      end else if (seen_in < len_in) begin
         fin_status = STATUS_LENGTH;
      end else if (early_in == STATUS_HEADER_CRC) begin
         fin_status = STATUS_HEADER_CRC;
      end else if ((crc_in ^ CRC_ONES) != pchk_in) begin
         fin_status = STATUS_PAYLOAD_CRC;
      end else begin
         fin_status = STATUS_OK;
      end
   end

   always_comb begin
      crc_in        = crc_ff;
      seen_in       = seen_ff;
      early_in      = early_ff;
      len_in        = len_ff;
      pchk_in       = pchk_ff;
      cur_slot_in   = cur_slot_ff;
      slot_valid_in = slot_valid_ff;
      slot_seq_in   = slot_seq_ff;
      open_in       = open_ff;
      finish        = 1'b0;
      has_result    = 1'b0;
      out_in        = out_ff;
      if (advance) begin
         unique case (in_ff.cmd)
            CMD_HEADER: begin
               early_in    = hdr_status;
               cur_slot_in = in_ff.slot;
               len_in      = in_ff.hdr_length;
               pchk_in     = in_ff.hdr_payload_check;
               crc_in      = CRC_ONES;
               seen_in     = 32'h0;
               open_in     = 1'b1;
               slot_valid_in[in_ff.slot] = 1'b0;
               slot_seq_in[in_ff.slot]   = in_ff.hdr_sequence;
               finish      = in_ff.last;
            end
            CMD_PAYLOAD: begin
               if (open_ff) begin
                  if (seen_ff < len_ff) begin
                     crc_in = crc_byte(crc_ff, in_ff.data_byte);
                  end
                  if (seen_ff != CRC_ONES) begin
                     seen_in = seen_ff + 32'd1;
                  end
                  finish = in_ff.last;
               end
            end
            CMD_SELECT: begin
               has_result             = 1'b1;
               out_in.result_kind     = KIND_SELECT;
               out_in.status          = STATUS_OK;
               out_in.status_slot     = 1'b0;
               priority if (!slot_valid_ff[0] && !slot_valid_ff[1]) begin
                  out_in.chosen          = CHOSEN_NONE;
                  out_in.chosen_sequence = 32'h0;
               end else if (!slot_valid_ff[0] || (slot_valid_ff[1] && b_newer)) begin
                  out_in.chosen          = CHOSEN_B;
                  out_in.chosen_sequence = slot_seq_ff[1];
               end else begin
                  out_in.chosen          = CHOSEN_A;
                  out_in.chosen_sequence = slot_seq_ff[0];
               end
            end
            default: begin
            end
         endcase
         if (finish) begin
            has_result                  = 1'b1;
            open_in                     = 1'b0;
            slot_valid_in[cur_slot_in]  = (fin_status == STATUS_OK);
            out_in.result_kind          = KIND_STATUS;
            out_in.status               = fin_status;
            out_in.status_slot          = cur_slot_in;
            out_in.chosen               = CHOSEN_NONE;
            out_in.chosen_sequence      = 32'h0;
         end
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = has_result;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         csr_ff        <= '0;
         crc_ff        <= CRC_ONES;
         seen_ff       <= 32'h0;
         early_ff      <= STATUS_OK;
         len_ff        <= 32'h0;
         pchk_ff       <= 32'h0;
         cur_slot_ff   <= 1'b0;
         slot_valid_ff <= 2'b00;
         slot_seq_ff   <= '0;
         open_ff       <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         crc_ff        <= crc_in;
         seen_ff       <= seen_in;
         early_ff      <= early_in;
         len_ff        <= len_in;
         pchk_ff       <= pchk_in;
         cur_slot_ff   <= cur_slot_in;
         slot_valid_ff <= slot_valid_in;
         slot_seq_ff   <= slot_seq_in;
         open_ff       <= open_in;
         if (csr_write) begin
            unique case (csr_index)
               CSR_RECORD_MAGIC:       csr_ff.record_magic       <= csr_data;
               CSR_EXPECTED_SCHEMA:    csr_ff.expected_schema    <= csr_data[15:0];
               CSR_MAX_PAYLOAD_LENGTH: csr_ff.max_payload_length <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_ff <= req_payload;
      end
      out_ff <= out_in;
   end

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import nrvs_pkg::*;

   localparam cmd_type CMD_UNUSED = cmd_type'(2'd3);
   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_SPAN = 150;
   localparam int SETTLE_CYCLES = 4;

   typedef enum {
      FLAW_NONE,
      FLAW_MAGIC,
      FLAW_SCHEMA,
      FLAW_HDR_CHECK,
      FLAW_PAY_CHECK,
      FLAW_UNFINISHED
   } flaw_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_payload;
   logic csr_write = 1'b0;
   logic [1:0] csr_index = CSR_RECORD_MAGIC;
   logic [31:0] csr_data = '0;

   // shadow of the block's registers and record state
   logic [31:0] cfg_magic = '0;
   logic [15:0] cfg_schema = '0;
   logic [31:0] cfg_max_length = '0;
   logic [31:0] pay_crc = CRC_ONES;
   logic [31:0] byte_count = '0;
   status_type hdr_verdict = STATUS_OK;
   logic [31:0] want_length = '0;
   logic [31:0] want_pcrc = '0;
   logic open_slot = 1'b0;
   logic [1:0] slot_ok = '0;
   logic [31:0] seq_store [2] = '{32'd0, 32'd0};
   logic record_live = 1'b0;

   rsp_type awaited_results [$];
   int requests_counted = 0;
   int error_count = 0;
   int quiet_cycles = 0;
   int stall_left = 0;
   bit hold_request = 1'b0;
   bit sender_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;

   nvm_record_validate_select_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int idle_span();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [31:0] crc32_byte(logic [31:0] acc, logic [7:0] b);
      logic [31:0] c;
      int k;
      c = acc ^ {24'd0, b};
      for (k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // little-endian packing: magic, schema, spare, sequence, length, payload check
   function automatic logic [31:0] header_check_of(req_type r);
      logic [159:0] image;
      logic [31:0] c;
      int k;
      image = {r.hdr_payload_check, r.hdr_length, r.hdr_sequence,
               r.hdr_spare, r.hdr_schema, r.hdr_magic};
      c = CRC_ONES;
      for (k = 0; k < 20; k++) begin
         c = crc32_byte(c, image[8*k +: 8]);
      end
      return ~c;
   endfunction

   function automatic void record_verdict(output rsp_type res);
      status_type st;
      if (hdr_verdict inside {STATUS_MAGIC, STATUS_SCHEMA, STATUS_LENGTH}) begin
         st = hdr_verdict;
      end else if (byte_count < want_length) begin
         st = STATUS_LENGTH;
      end else if (hdr_verdict == STATUS_HEADER_CRC) begin
         st = STATUS_HEADER_CRC;
      end else if (~pay_crc != want_pcrc) begin
         st = STATUS_PAYLOAD_CRC;
      end else begin
         st = STATUS_OK;
      end
      slot_ok[open_slot] = (st == STATUS_OK);
      record_live = 1'b0;
      res = '0;
      res.result_kind = KIND_STATUS;
      res.status = st;
      res.status_slot = open_slot;
      res.chosen = CHOSEN_NONE;
   endfunction

   function automatic bit result_of_request(input req_type r, output rsp_type res);
      logic [31:0] seq_gap;
      res = '0;
      case (r.cmd)
         CMD_HEADER: begin
            if (r.hdr_magic != cfg_magic) hdr_verdict = STATUS_MAGIC;
            else if (r.hdr_schema != cfg_schema) hdr_verdict = STATUS_SCHEMA;
            else if (r.hdr_length > cfg_max_length) hdr_verdict = STATUS_LENGTH;
            else if (header_check_of(r) != r.hdr_header_check) hdr_verdict = STATUS_HEADER_CRC;
            else hdr_verdict = STATUS_OK;
            open_slot = r.slot;
            want_length = r.hdr_length;
            want_pcrc = r.hdr_payload_check;
            pay_crc = CRC_ONES;
            byte_count = '0;
            slot_ok[r.slot] = 1'b0;
            seq_store[r.slot] = r.hdr_sequence;
            record_live = 1'b1;
            if (r.last) begin
               record_verdict(res);
               return 1'b1;
            end
            return 1'b0;
         end
         CMD_PAYLOAD: begin
            if (!record_live) return 1'b0;
            if (byte_count < want_length) pay_crc = crc32_byte(pay_crc, r.data_byte);
            if (byte_count != '1) byte_count++;
            if (r.last) begin
               record_verdict(res);
               return 1'b1;
            end
            return 1'b0;
         end
         CMD_SELECT: begin
            res.result_kind = KIND_SELECT;
            seq_gap = seq_store[1] - seq_store[0];
            if (slot_ok == 2'b00) begin
               res.chosen = CHOSEN_NONE;
            end else if (!slot_ok[0] || (slot_ok[1] && seq_store[1] != seq_store[0]
                                         && seq_gap < HALF_RANGE)) begin
               res.chosen = CHOSEN_B;
               res.chosen_sequence = seq_store[1];
            end else begin
               res.chosen = CHOSEN_A;
               res.chosen_sequence = seq_store[0];
            end
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   function automatic req_type noise_request();
      logic [223:0] bits;
      bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      return req_type'(bits[$bits(req_type)-1:0]);
   endfunction

   function automatic req_type select_request();
      req_type r;
      r = noise_request();
      r.cmd = CMD_SELECT;
      return r;
   endfunction

   function automatic req_type byte_request(logic [7:0] b, logic last);
      req_type r;
      r = noise_request();
      r.cmd = CMD_PAYLOAD;
      r.data_byte = b;
      r.last = last;
      return r;
   endfunction

   function automatic logic [31:0] pick_sequence(logic slot);
      logic [31:0] other;
      int roll;
      other = seq_store[~slot];
      roll = $urandom_range(0, 99);
      if (roll < 50) return $urandom;
      if (roll < 75) return other + 32'($urandom_range(0, 6)) - 32'd3;
      if (roll < 85) return other + HALF_RANGE;
      return other;
   endfunction

   task automatic send_request(input req_type r);
      int gap;
      rsp_type res;
      gap = sender_idle_on ? idle_span() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (!(r.cmd == CMD_UNUSED || (r.cmd == CMD_PAYLOAD && !record_live))) begin
         requests_counted++;
      end
      if (result_of_request(r, res)) awaited_results.push_back(res);
   endtask

   task automatic send_record(input logic slot, input logic [31:0] seq,
                              input logic [31:0] len, input int delivered,
                              input flaw_type flaw);
      logic [7:0] data [$];
      logic [31:0] acc;
      req_type hdr;
      int k;
      acc = CRC_ONES;
      for (k = 0; k < delivered; k++) begin
         data.push_back(8'($urandom));
         if (k < len) acc = crc32_byte(acc, data[k]);
      end
      hdr = noise_request();
      hdr.cmd = CMD_HEADER;
      hdr.slot = slot;
      hdr.hdr_magic = cfg_magic;
      hdr.hdr_schema = cfg_schema;
      hdr.hdr_sequence = seq;
      hdr.hdr_length = len;
      hdr.hdr_payload_check = ~acc;
      if (flaw == FLAW_MAGIC) hdr.hdr_magic ^= $urandom | (32'd1 << $urandom_range(0, 31));
      if (flaw == FLAW_SCHEMA) hdr.hdr_schema ^= 16'($urandom_range(1, 65535));
      if (flaw == FLAW_PAY_CHECK) begin
         hdr.hdr_payload_check ^= $urandom | (32'd1 << $urandom_range(0, 31));
      end
      hdr.hdr_header_check = header_check_of(hdr);
      if (flaw == FLAW_HDR_CHECK) begin
         hdr.hdr_header_check ^= $urandom | (32'd1 << $urandom_range(0, 31));
      end
      hdr.last = (delivered == 0) && (flaw != FLAW_UNFINISHED);
      send_request(hdr);
      for (k = 0; k < delivered; k++) begin
         send_request(byte_request(data[k], k == delivered - 1 && flaw != FLAW_UNFINISHED));
      end
   endtask

   task automatic wait_results_done();
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic [31:0] magic, input logic [15:0] schema,
                             input logic [31:0] max_len);
      wait_results_done();
      csr_write <= 1'b1;
      csr_index <= CSR_RECORD_MAGIC;
      csr_data <= magic;
      @(posedge clock);
      cfg_magic = magic;
      csr_index <= CSR_EXPECTED_SCHEMA;
      csr_data <= {16'd0, schema};
      @(posedge clock);
      cfg_schema = schema;
      csr_index <= CSR_MAX_PAYLOAD_LENGTH;
      csr_data <= max_len;
      @(posedge clock);
      cfg_max_length = max_len;
      csr_write <= 1'b0;
   endtask

   // registers still at their reset values
   task automatic test_reset_defaults();
      send_request(select_request());
      send_record(1'b0, 32'd0, 32'd0, 0, FLAW_NONE);
      send_request(select_request());
   endtask

   task automatic test_header_checks();
      set_config($urandom, 16'($urandom), 32'd8);
      send_record(1'b0, $urandom, 32'd0, 0, FLAW_MAGIC);
      send_record(1'b1, $urandom, 32'd0, 0, FLAW_SCHEMA);
      send_record(1'b0, $urandom, 32'hFFFF_FFFF, 0, FLAW_NONE);
      send_record(1'b1, $urandom, 32'd0, 0, FLAW_HDR_CHECK);
   endtask

   task automatic test_payload_checks();
      req_type r;
      send_record(1'b0, $urandom, 32'd3, 2, FLAW_NONE);
      send_record(1'b1, $urandom, 32'd1, 1, FLAW_PAY_CHECK);
      send_record(1'b1, 32'd5, 32'd1, 2, FLAW_NONE);
      send_request(select_request());
      send_request(byte_request($urandom, 1'b1));
      r = noise_request();
      r.cmd = CMD_UNUSED;
      send_request(r);
      send_record(1'b0, $urandom, 32'd2, 0, FLAW_UNFINISHED);
      send_record(1'b0, 32'hFFFF_FFF0, 32'd0, 0, FLAW_NONE);
   endtask

   task automatic test_slot_selection();
      send_request(select_request());
      send_record(1'b1, 32'hFFFF_FFF0, 32'd0, 0, FLAW_NONE);
      send_request(select_request());
   endtask

   task automatic test_output_holdoff();
      int k;
      sender_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      hold_request = 1'b1;
      for (k = 0; k < 24; k++) begin
         if (k % 2 == 0) send_request(select_request());
         else send_record(1'($urandom), $urandom, 32'd0, 0, FLAW_NONE);
      end
      sender_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   task automatic test_sender_pause();
      send_record(1'b0, $urandom, 32'd4, 4, FLAW_NONE);
      send_request(select_request());
      wait_results_done();
      send_record(1'b1, $urandom, 32'd2, 2, FLAW_NONE);
      send_request(select_request());
   endtask

   task automatic test_random_records(input int quota);
      int stop_at;
      int roll;
      int delivered;
      logic [31:0] len;
      logic slot;
      flaw_type flaw;
      stop_at = requests_counted + quota;
      while (requests_counted < stop_at) begin
         roll = $urandom_range(0, 99);
         if (roll < 12) begin
            send_request(select_request());
         end else if (roll < 16) begin
            send_request(noise_request());
         end else begin
            slot = 1'($urandom);
            roll = $urandom_range(0, 99);
            if (roll < 5) len = $urandom;
            else if (roll < 15) len = $urandom_range(7, 40);
            else len = $urandom_range(0, 6);
            delivered = (len > 40) ? $urandom_range(0, 4) : int'(len);
            roll = $urandom_range(0, 99);
            if (roll < 10 && delivered > 0) delivered -= $urandom_range(1, delivered);
            else if (roll < 22) delivered += $urandom_range(1, 3);
            flaw = ($urandom_range(0, 99) < 70) ? FLAW_NONE : flaw_type'($urandom_range(1, 5));
            send_record(slot, pick_sequence(slot), len, delivered, flaw);
         end
      end
   endtask

   always @(posedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         stall_left = HOLD_SPAN;
      end else if (stall_left == 0 && rsp_idle_on && $urandom_range(0, 99) < 25) begin
         stall_left = idle_span();
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_results.size() == 0) begin
            error_count++;
            if (error_count <= 10) begin
               $display("%0t: unexpected result kind %0d status %0d slot %0d chosen %0d seq %08h",
                        $realtime, rsp_payload.result_kind, rsp_payload.status,
                        rsp_payload.status_slot, rsp_payload.chosen,
                        rsp_payload.chosen_sequence);
            end
         end else begin
            want = awaited_results.pop_front();
            if (rsp_payload.result_kind !== want.result_kind
                || rsp_payload.status !== want.status
                || rsp_payload.status_slot !== want.status_slot
                || rsp_payload.chosen !== want.chosen
                || rsp_payload.chosen_sequence !== want.chosen_sequence) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("%0t: got kind %0d status %0d slot %0d chosen %0d seq %08h",
                           $realtime, rsp_payload.result_kind, rsp_payload.status,
                           rsp_payload.status_slot, rsp_payload.chosen,
                           rsp_payload.chosen_sequence);
                  $display("   expected kind %0d status %0d slot %0d chosen %0d seq %08h",
                           want.result_kind, want.status, want.status_slot,
                           want.chosen, want.chosen_sequence);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("tb_top: done, errors");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_header_checks();
      test_payload_checks();
      test_slot_selection();
      test_output_holdoff();
      test_sender_pause();
      set_config($urandom, 16'($urandom), 32'd8);
      test_random_records(95);
      set_config(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
      test_random_records(95);
      set_config(32'd0, 16'd0, 32'd0);
      sender_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      test_random_records(80);
      sender_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      set_config($urandom, 16'($urandom), 32'd40);
      test_random_records(95);
      wait_results_done();
      if (error_count == 0 && awaited_results.size() == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
